// ===== rtl/core/mp2d_pkg.sv =====
package mp2d_pkg;

  localparam int MaxCols     = 64;
  localparam int MaxWindow   = 8;
  localparam int MaxRows     = 64;
  localparam int MaxChannels = 64;

  localparam int ValueW   = 16;
  localparam int PosW     = 6;
  localparam int SizeW    = 7;
  localparam int WinW     = 4;
  localparam int ColAddrW = $clog2(MaxCols);
  localparam int RowAddrW = $clog2(MaxWindow);
  localparam int AddrW    = ColAddrW + RowAddrW;
  localparam int StoreDepth = MaxWindow * MaxCols;
  localparam int OffW     = $clog2(MaxWindow);
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INPUT_ROWS    = 3'd0,
    CFG_INPUT_COLS    = 3'd1,
    CFG_CHANNEL_COUNT = 3'd2,
    CFG_WINDOW_ROWS   = 3'd3,
    CFG_WINDOW_COLS   = 3'd4,
    CFG_STEP          = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } mp_state_e;

endpackage

// ===== rtl/core/max_pool_2d_with_argmax.sv =====
// a word at no window position is only stored; a word that closes a window has its
// stride remainder checked bit by bit, and a window on the stride grid is scanned (one
// line-store read a cycle), drained and its result put in the output register; no new
// word is taken until the block is idle again, and a result word still held for
// out_ready_i keeps the block in its output state until taken
// reset: control registers take their reset values, positions return to zero, data registers and line store undefined
module max_pool_2d_with_argmax (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mp2d_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mp2d_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [mp2d_pkg::ValueW-1:0] sample_value_i,
  input  logic                            sample_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [mp2d_pkg::ValueW-1:0] pooled_value_o,
  output logic [mp2d_pkg::PosW-1:0]       max_channel_o,
  output logic [mp2d_pkg::PosW-1:0]       max_row_o,
  output logic [mp2d_pkg::PosW-1:0]       max_col_o,
  output logic                            sample_done_o
);
  import mp2d_pkg::*;

  // configuration registers
  logic [SizeW-1:0] rows_cfg_q, cols_cfg_q, chans_cfg_q;
  logic [WinW-1:0]  wr_cfg_q, wc_cfg_q, step_cfg_q;

  logic [SizeW-1:0] rows, cols, chans;
  logic [WinW-1:0]  wr, wc, st;

  mp_state_e state_q, state_d;

  logic [PosW-1:0] col_pos_q, row_pos_q, chan_pos_q;
  logic [PosW-1:0] top_q, left_q, chan_q;
  logic            last_q;
  logic [WinW:0]   rem_top_q, rem_left_q;
  logic [2:0]      mod_cnt_q;
  logic [OffW-1:0] roff_q, coff_q;

  logic                     rd_vld_q, rd_first_q, rd_last_q;
  logic [PosW-1:0]          rd_row_q, rd_col_q;
  logic signed [ValueW-1:0] rdata_q;
  logic signed [ValueW-1:0] best_q;
  logic [PosW-1:0]          best_row_q, best_col_q;

  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_value_q;
  logic [PosW-1:0]          out_chan_q, out_row_q, out_col_q;
  logic                     out_done_q;

  logic signed [ValueW-1:0] line_store [StoreDepth];

  // effective sizes
  always_comb begin
    rows  = (rows_cfg_q == '0) ? SizeW'(1) :
            (rows_cfg_q > SizeW'(MaxRows)) ? SizeW'(MaxRows) : rows_cfg_q;
    cols  = (cols_cfg_q == '0) ? SizeW'(1) :
            (cols_cfg_q > SizeW'(MaxCols)) ? SizeW'(MaxCols) : cols_cfg_q;
    chans = (chans_cfg_q == '0) ? SizeW'(1) :
            (chans_cfg_q > SizeW'(MaxChannels)) ? SizeW'(MaxChannels) : chans_cfg_q;
    wr    = (wr_cfg_q == '0) ? WinW'(1) :
            (wr_cfg_q > WinW'(MaxWindow)) ? WinW'(MaxWindow) : wr_cfg_q;
    wc    = (wc_cfg_q == '0) ? WinW'(1) :
            (wc_cfg_q > WinW'(MaxWindow)) ? WinW'(MaxWindow) : wc_cfg_q;
    st    = (step_cfg_q == '0) ? WinW'(1) : step_cfg_q;
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q  <= SizeW'(8);
      cols_cfg_q  <= SizeW'(8);
      chans_cfg_q <= SizeW'(1);
      wr_cfg_q    <= WinW'(2);
      wc_cfg_q    <= WinW'(2);
      step_cfg_q  <= WinW'(2);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INPUT_ROWS:    rows_cfg_q  <= cfg_data_i;
        CFG_INPUT_COLS:    cols_cfg_q  <= cfg_data_i;
        CFG_CHANNEL_COUNT: chans_cfg_q <= cfg_data_i;
        CFG_WINDOW_ROWS:   wr_cfg_q    <= cfg_data_i[WinW-1:0];
        CFG_WINDOW_COLS:   wc_cfg_q    <= cfg_data_i[WinW-1:0];
        CFG_STEP:          step_cfg_q  <= cfg_data_i[WinW-1:0];
        default: ;
      endcase
    end
  end

  // position of the incoming word, wrapped
  logic [PosW-1:0]  cur_col, cur_row, cur_chan;
  logic [SizeW-1:0] col_inc, row_inc, chan_inc;
  logic             win_hit;
  logic [SizeW-1:0] top_full, left_full;
  logic             last_c;

  always_comb begin
    cur_col  = sample_start_i ? '0 : col_pos_q;
    cur_row  = sample_start_i ? '0 : row_pos_q;
    cur_chan = sample_start_i ? '0 : chan_pos_q;
    if ({1'b0, cur_col} >= cols)   cur_col  = '0;
    if ({1'b0, cur_row} >= rows)   cur_row  = '0;
    if ({1'b0, cur_chan} >= chans) cur_chan = '0;
    col_inc  = {1'b0, cur_col} + SizeW'(1);
    row_inc  = {1'b0, cur_row} + SizeW'(1);
    chan_inc = {1'b0, cur_chan} + SizeW'(1);
    win_hit  = (row_inc >= SizeW'(wr)) && (col_inc >= SizeW'(wc));
    top_full  = row_inc - SizeW'(wr);
    left_full = col_inc - SizeW'(wc);
    last_c = (chan_inc == chans) &&
             ((8'(top_full) + 8'(st) + 8'(wr)) > 8'(rows)) &&
             ((8'(left_full) + 8'(st) + 8'(wc)) > 8'(cols));
  end

  // remainder step for the stride check
  logic [WinW:0] rt_shift, rl_shift, rt_next, rl_next;
  always_comb begin
    rt_shift = {rem_top_q[WinW-1:0], top_q[mod_cnt_q]};
    rl_shift = {rem_left_q[WinW-1:0], left_q[mod_cnt_q]};
    rt_next  = (rt_shift >= {1'b0, st}) ? rt_shift - {1'b0, st} : rt_shift;
    rl_next  = (rl_shift >= {1'b0, st}) ? rl_shift - {1'b0, st} : rl_shift;
  end

  logic            in_acc;
  logic            scan_end;
  logic [PosW-1:0] scan_row, scan_col;

  always_comb begin
    scan_row = top_q + PosW'(roff_q);
    scan_col = left_q + PosW'(coff_q);
    scan_end = (roff_q == OffW'(wr - WinW'(1))) && (coff_q == OffW'(wc - WinW'(1)));
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    in_acc     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        in_acc     = in_valid_i;
        if (in_valid_i && win_hit) state_d = ST_MOD;
      end
      ST_MOD: begin
        if (mod_cnt_q == '0) begin
          state_d = (rt_next == '0 && rl_next == '0) ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (rd_vld_q && rd_last_q) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_pos_q   <= '0;
      row_pos_q   <= '0;
      chan_pos_q  <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SCAN);
      if (in_acc) begin
        if (col_inc >= cols) begin
          col_pos_q <= '0;
          if (row_inc >= rows) begin
            row_pos_q  <= '0;
            chan_pos_q <= (chan_inc >= chans) ? '0 : chan_inc[PosW-1:0];
          end else begin
            row_pos_q  <= row_inc[PosW-1:0];
            chan_pos_q <= cur_chan;
          end
        end else begin
          col_pos_q  <= col_inc[PosW-1:0];
          row_pos_q  <= cur_row;
          chan_pos_q <= cur_chan;
        end
      end
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      top_q      <= top_full[PosW-1:0];
      left_q     <= left_full[PosW-1:0];
      chan_q     <= cur_chan;
      last_q     <= last_c;
      rem_top_q  <= '0;
      rem_left_q <= '0;
      mod_cnt_q  <= 3'(PosW - 1);
    end
    if (state_q == ST_MOD) begin
      rem_top_q  <= rt_next;
      rem_left_q <= rl_next;
      mod_cnt_q  <= mod_cnt_q - 3'd1;
      roff_q     <= '0;
      coff_q     <= '0;
    end
    if (state_q == ST_SCAN) begin
      if (coff_q == OffW'(wc - WinW'(1))) begin
        coff_q <= '0;
        roff_q <= roff_q + OffW'(1);
      end else begin
        coff_q <= coff_q + OffW'(1);
      end
    end
    rd_row_q   <= scan_row;
    rd_col_q   <= scan_col;
    rd_first_q <= (roff_q == '0) && (coff_q == '0);
    rd_last_q  <= scan_end;
    // first word of the window seeds the maximum, later ones win only if larger
    if (rd_vld_q && (rd_first_q || rdata_q > best_q)) begin
      best_q     <= rdata_q;
      best_row_q <= rd_row_q;
      best_col_q <= rd_col_q;
    end
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_value_q <= best_q;
      out_chan_q  <= chan_q;
      out_row_q   <= best_row_q;
      out_col_q   <= best_col_q;
      out_done_q  <= last_q;
    end
  end

  // line store, row slot is the row modulo the maximum window depth
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_store[{cur_row[RowAddrW-1:0], cur_col[ColAddrW-1:0]}] <= sample_value_i;
    end
    rdata_q <= line_store[{scan_row[RowAddrW-1:0], scan_col[ColAddrW-1:0]}];
  end

  assign out_valid_o    = out_valid_q;
  assign pooled_value_o = out_value_q;
  assign max_channel_o  = out_chan_q;
  assign max_row_o      = out_row_q;
  assign max_col_o      = out_col_q;
  assign sample_done_o  = out_done_q;

endmodule

// ===== dv/tb.sv =====
module tb;
  import mp2d_pkg::*;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     start;
  } feed_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          chan;
    logic [PosW-1:0]          row;
    logic [PosW-1:0]          col;
    logic                     done;
  } pool_res_t;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       cfg_valid    = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index    = '0;
  logic [CfgDataW-1:0]        cfg_data     = '0;
  logic                       in_valid     = 1'b0;
  logic signed [ValueW-1:0]   sample_value = '0;
  logic                       sample_start = 1'b0;
  logic                       out_ready    = 1'b0;
  logic                       cfg_ready;
  logic                       in_ready;
  logic                       out_valid;
  logic signed [ValueW-1:0]   pooled_value;
  logic [PosW-1:0]            max_channel;
  logic [PosW-1:0]            max_row;
  logic [PosW-1:0]            max_col;
  logic                       sample_done;

  feed_t       feed_q[$];
  pool_res_t   pooled_q[$];
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // register copies as the block holds them
  logic [SizeW-1:0] reg_rows  = 7'd8;
  logic [SizeW-1:0] reg_cols  = 7'd8;
  logic [SizeW-1:0] reg_chans = 7'd1;
  logic [WinW-1:0]  reg_wr    = 4'd2;
  logic [WinW-1:0]  reg_wc    = 4'd2;
  logic [WinW-1:0]  reg_step  = 4'd2;

  logic [ValueW-1:0] line_mem [StoreDepth];
  int unsigned       col_at  = 0;
  int unsigned       row_at  = 0;
  int unsigned       chan_at = 0;

  logic signed [ValueW-1:0] corner_vals [26] = '{
    16'sh8000, 16'sh8000, 16'sd5, 16'sd5, 16'sh7fff, -16'sd1, 16'sd0, 16'sd0,
    16'sh8000, 16'sh8000, 16'sd5, 16'sd7, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd1,
    16'sh7fff, 16'sh8000, 16'sd1, -16'sd1,
    16'sd1, 16'sd2, 16'sd3, 16'sd4, -16'sd5, 16'sd6};
  // rows, cols, channels, window rows, window cols, step, words
  int unsigned plan [10][7] = '{
    '{4, 4, 1, 2, 2, 2, 40},
    '{0, 0, 0, 0, 0, 0, 10},
    '{127, 1, 1, 15, 0, 1, 64},
    '{1, 127, 1, 1, 127, 15, 64},
    '{2, 8, 3, 4, 2, 1, 24},
    '{6, 7, 2, 3, 3, 2, 42},
    '{1, 1, 127, 1, 1, 1, 64},
    '{5, 5, 1, 5, 5, 1, 25},
    '{8, 8, 1, 8, 8, 1, 64},
    '{3, 9, 1, 2, 3, 3, 27}};

  max_pool_2d_with_argmax u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_value_i (sample_value),
    .sample_start_i (sample_start),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pooled_value_o (pooled_value),
    .max_channel_o  (max_channel),
    .max_row_o      (max_row),
    .max_col_o      (max_col),
    .sample_done_o  (sample_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // stores one word and, when it closes a window, scans it for the maximum
  function automatic bit pool_step(input logic signed [ValueW-1:0] v, input logic start,
                                   output pool_res_t res);
    int unsigned rows, cols, chans, wr, wc, st, top, left, br, bc;
    logic signed [ValueW-1:0] best, cand;
    rows  = eff_size(reg_rows, MaxRows);
    cols  = eff_size(reg_cols, MaxCols);
    chans = eff_size(reg_chans, MaxChannels);
    wr    = eff_size(reg_wr, MaxWindow);
    wc    = eff_size(reg_wc, MaxWindow);
    st    = (reg_step == 0) ? 1 : reg_step;
    res   = '0;
    pool_step = 1'b0;
    if (start) begin
      col_at = 0;
      row_at = 0;
      chan_at = 0;
    end
    if (col_at >= cols) col_at = 0;
    if (row_at >= rows) row_at = 0;
    if (chan_at >= chans) chan_at = 0;
    line_mem[(row_at % MaxWindow) * MaxCols + col_at] = v;
    if (row_at + 1 >= wr && col_at + 1 >= wc) begin
      top  = row_at + 1 - wr;
      left = col_at + 1 - wc;
      if (top % st == 0 && left % st == 0) begin
        best = line_mem[(top % MaxWindow) * MaxCols + left];
        br = top;
        bc = left;
        // raster order, strict compare keeps the first of equal values
        for (int unsigned r = top; r <= row_at; r++) begin
          for (int unsigned c = left; c <= col_at; c++) begin
            cand = line_mem[(r % MaxWindow) * MaxCols + c];
            if (cand > best) begin
              best = cand;
              br = r;
              bc = c;
            end
          end
        end
        res.value = best;
        res.chan  = PosW'(chan_at);
        res.row   = PosW'(br);
        res.col   = PosW'(bc);
        res.done  = (chan_at + 1 == chans) && (top + st + wr > rows) && (left + st + wc > cols);
        pool_step = 1'b1;
      end
    end
    col_at = col_at + 1;
    if (col_at >= cols) begin
      col_at = 0;
      row_at = row_at + 1;
      if (row_at >= rows) begin
        row_at = 0;
        chan_at = chan_at + 1;
        if (chan_at >= chans) chan_at = 0;
      end
    end
  endfunction

  always @(posedge clk or negedge rst_n) begin : driver
    pool_res_t res;
    feed_t     nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (pool_step(sample_value, sample_start, res)) pooled_q.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = feed_q.pop_front();
          in_valid     <= 1'b1;
          sample_value <= nxt.value;
          sample_start <= nxt.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : monitor
    pool_res_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {pooled_value, max_channel, max_row, max_col, sample_done};
        if (pooled_q.size() == 0) begin
          $display("%0t: unexpected word: value %0d chan %0d row %0d col %0d done %0b",
                   $time, got.value, got.chan, got.row, got.col, got.done);
          mismatches++;
        end else begin
          want = pooled_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected value %0d chan %0d row %0d col %0d done %0b", $time,
                     want.value, want.chan, want.row, want.col, want.done);
            $display("%0t: actual   value %0d chan %0d row %0d col %0d done %0b", $time,
                     got.value, got.chan, got.row, got.col, got.done);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_INPUT_ROWS:    reg_rows  = data;
      CFG_INPUT_COLS:    reg_cols  = data;
      CFG_CHANNEL_COUNT: reg_chans = data;
      CFG_WINDOW_ROWS:   reg_wr    = data[WinW-1:0];
      CFG_WINDOW_COLS:   reg_wc    = data[WinW-1:0];
      CFG_STEP:          reg_step  = data[WinW-1:0];
      default: ;
    endcase
  endtask

  // all words sent and all results back, then let a window scan run out
  task automatic drain_and_wait();
    while (feed_q.size() != 0 || in_valid || pooled_q.size() != 0) @(negedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned rows, cols, chans, wr, wc, st, count, mode);
    int unsigned sample_len, pos, items;
    feed_t       f;
    write_reg(CFG_INPUT_ROWS,    CfgDataW'(rows));
    write_reg(CFG_INPUT_COLS,    CfgDataW'(cols));
    write_reg(CFG_CHANNEL_COUNT, CfgDataW'(chans));
    write_reg(CFG_WINDOW_ROWS,   CfgDataW'(wr));
    write_reg(CFG_WINDOW_COLS,   CfgDataW'(wc));
    write_reg(CFG_STEP,          CfgDataW'(st));
    sample_len = eff_size(reg_rows, MaxRows) * eff_size(reg_cols, MaxCols) *
                 eff_size(reg_chans, MaxChannels);
    items = (count < 3 * sample_len) ? count : 3 * sample_len;
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
    pos = 0;
    repeat (items) begin
      // mostly whole samples, now and then a restart part way through
      f.start = (pos == 0) || ($urandom_range(99) < 3);
      if (f.start) pos = 0;
      case ($urandom_range(9))
        0:       f.value = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        1, 2:    f.value = ValueW'($urandom_range(2)) - 16'd1;
        default: f.value = ValueW'($urandom());
      endcase
      feed_q.push_back(f);
      pos = (pos + 1) % sample_len;
    end
    drain_and_wait();
  endtask

  initial begin : stimulus
    int i;
    int unsigned p;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: ties, extremes, a window with its max in the last word
    for (i = 0; i < 20; i++) feed_q.push_back(feed_t'{corner_vals[i], i == 0});
    drain_and_wait();
    // shrink the plane under the current position so both positions wrap
    write_reg(CFG_INPUT_ROWS, 7'd2);
    write_reg(CFG_INPUT_COLS, 7'd3);
    for (i = 20; i < 26; i++) feed_q.push_back(feed_t'{corner_vals[i], 1'b0});
    drain_and_wait();

    for (p = 0; p < 10; p++) begin
      run_phase(plan[p][0], plan[p][1], plan[p][2], plan[p][3], plan[p][4], plan[p][5],
                plan[p][6], p % 4);
    end
    for (p = 10; p < 14; p++) begin
      run_phase($urandom_range(12, 1), $urandom_range(12, 1), $urandom_range(3, 1),
                $urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(4, 1), 10, p % 4);
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(500000 * 12);
    $display("simulation failed");
    $finish;
  end

endmodule
